[sv/frtrk_pkg.sv]
// ----------------------------------------------------------------------------
// frtrk_pkg
// shared types and codes of the frame reassembly nack tracker
// ----------------------------------------------------------------------------
package frtrk_pkg;

  localparam logic [1:0] ACT_CHUNK = 2'd0;
  localparam logic [1:0] ACT_POLL  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] KIND_STORED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_DELIVERED = 3'd2;
  localparam logic [2:0] KIND_NACK      = 3'd3;
  localparam logic [2:0] KIND_FLUSHED   = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;

  localparam logic [1:0] CFG_MAX_PENDING    = 2'd0;
  localparam logic [1:0] CFG_DROP_AFTER_MS  = 2'd1;
  localparam logic [1:0] CFG_NACK_AFTER_MS  = 2'd2;
  localparam logic [1:0] CFG_NACK_REPEAT_MS = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] frame_seq;
    logic [15:0] chunk_index;
    logic [15:0] chunk_count;
    logic        is_keyframe;
    logic [63:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_seq;
    logic [3:0]  slot;
    logic        out_keyframe;
    logic [63:0] missing_mask;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [6:0]  total;
    logic [6:0]  have;
    logic        key;
    logic [63:0] received;
    logic [63:0] first_ms;
    logic [63:0] last_nack_ms;
    logic        nacked;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_CHUNK_UPD,
    ST_CHUNK_CNT,
    ST_DLV,
    ST_BEST_POST,
    ST_EXP_POST,
    ST_POLL_POST,
    ST_POLL_EVAL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    SC_HIT,
    SC_BEST,
    SC_PRUNE,
    SC_EXP,
    SC_POLL
  } scan_e;

endpackage

[sv/frame_reassembly_nack_tracker_top.sv]
// ----------------------------------------------------------------------------
// frame_reassembly_nack_tracker_top
// reassembly tracker for chunked frames with in-order delivery and nack polling
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a clock edge with start_i high and busy_o low;
//   in_i carries the action (chunk, poll, reset tracker) and its fields.
//   results leave on res_o, one per cycle at most, each marked by res_valid_o
//   for exactly one cycle; the last result of a transaction has last set.
//   the receiver cannot stall; res_o has no back-pressure.
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
//   the user must do so only while busy_o is low; the block does not enforce it.
// timing:
//   the pending table lives in a synchronous memory; every table search walks
//   all SLOTS entries, with a setup state before it and a decision state after.
//   a malformed or stale chunk needs no search; a stored chunk that hands out
//   d frames runs d+2 searches (two more on a keyframe resync) and a poll
//   over p pending frames runs p+1. the last result is on res_o in the first
//   cycle with busy_o low.
// reset:
//   rst_ni clears the valid bits and tracker state and loads the register
//   defaults; the memory itself needs no clearing.
// ----------------------------------------------------------------------------
module frame_reassembly_nack_tracker_top #(
  parameter int SLOTS      = 16,
  parameter int MAX_CHUNKS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  frtrk_pkg::in_t    in_i,
  output logic              res_valid_o,
  output frtrk_pkg::res_t   res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  frtrk_pkg::state_e state_q, state_d;
  frtrk_pkg::scan_e  mode_q, mode_d;

  logic [3:0]  max_pending_q;
  logic [15:0] drop_after_q, nack_after_q, nack_repeat_q;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic             started_q, started_d;
  logic             need_key_q, need_key_d;
  logic [31:0]      expected_q, expected_d;
  logic [31:0]      newest_q, newest_d;
  logic [31:0]      prev_q, prev_d;
  logic             prev_v_q, prev_v_d;

  frtrk_pkg::in_t   in_q;
  frtrk_pkg::entry_t mem [SLOTS];
  frtrk_pkg::entry_t rd_data_q, cand_e_q, cand_e_d, mem_wdata;
  logic [SW-1:0]    rd_addr, rd_idx_q, cand_idx_q, cand_idx_d, mem_waddr;
  logic             rd_req, rd_v_q, mem_we;
  logic             cand_v_q, cand_v_d;
  logic [SW:0]      scan_a_q, scan_a_d;

  frtrk_pkg::res_t  res_q, res_d, pend_q, pend_d, push_res;
  logic             res_valid_q, res_valid_d, pend_v_q, pend_v_d, push, fin;

  logic             bogus, stale, scan_last, match, hit_bad, free_v, pend_over;
  logic             exp_ok, drop, due, nack_go;
  logic [SW-1:0]    free_idx;
  logic [63:0]      bit_mask, age, since_nack, full_mask;
  logic [31:0]      seq_dif, nw_dif, inw_dif;

  assign busy_o      = (state_q != frtrk_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // shared conditions
  always_comb begin
    seq_dif   = in_q.frame_seq - expected_q;
    inw_dif   = in_q.frame_seq - newest_q;
    nw_dif    = newest_q - cand_e_q.seq;
    bogus     = (in_q.chunk_count == 16'd0) || (in_q.chunk_index >= in_q.chunk_count) ||
                (in_q.chunk_count > 16'(MAX_CHUNKS));
    stale     = started_q && seq_dif[31];
    scan_last = rd_v_q && (rd_idx_q == SW'(SLOTS - 1));
    bit_mask  = 64'd1 << in_q.chunk_index[5:0];
    hit_bad   = (cand_e_q.total != in_q.chunk_count[6:0]) ||
                ((cand_e_q.received & bit_mask) != 64'd0);
    free_v    = 1'b0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v   = 1'b1;
        free_idx = SW'(i);
      end
    end
    pend_over  = $countones(valid_q) > 32'(max_pending_q);
    exp_ok     = cand_v_q && (cand_e_q.have == cand_e_q.total);
    age        = in_q.now_ms - cand_e_q.first_ms;
    since_nack = in_q.now_ms - cand_e_q.last_nack_ms;
    drop       = age > 64'(drop_after_q);
    due        = cand_e_q.nacked ? (since_nack >= 64'(nack_repeat_q))
                                 : (age >= 64'(nack_after_q));
    nack_go    = (nw_dif != 32'd0) && !nw_dif[31] && due;
    full_mask  = (cand_e_q.total >= 7'd64) ? '1 : ((64'd1 << cand_e_q.total[5:0]) - 64'd1);
    match      = 1'b0;
    if (rd_v_q && valid_q[rd_idx_q]) begin
      unique case (mode_q)
        frtrk_pkg::SC_HIT:   match = (rd_data_q.seq == in_q.frame_seq);
        frtrk_pkg::SC_BEST:  match = rd_data_q.key && (rd_data_q.have == rd_data_q.total) &&
                                     (!cand_v_q || rd_data_q.seq < cand_e_q.seq);
        frtrk_pkg::SC_PRUNE: match = (rd_data_q.seq < expected_q);
        frtrk_pkg::SC_EXP:   match = (rd_data_q.seq == expected_q);
        frtrk_pkg::SC_POLL:  match = (!prev_v_q || rd_data_q.seq > prev_q) &&
                                     (!cand_v_q || rd_data_q.seq < cand_e_q.seq);
        default:             match = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frtrk_pkg::ST_IDLE: if (start_i) state_d = frtrk_pkg::ST_CHK;
      frtrk_pkg::ST_CHK: begin
        case (in_q.action)
          frtrk_pkg::ACT_CHUNK: state_d = (bogus || stale) ? frtrk_pkg::ST_FIN
                                                           : frtrk_pkg::ST_SCAN;
          frtrk_pkg::ACT_POLL:  state_d = frtrk_pkg::ST_SCAN;
          default:              state_d = frtrk_pkg::ST_FIN;
        endcase
      end
      frtrk_pkg::ST_SCAN: begin
        if (scan_last) begin
          unique case (mode_q)
            frtrk_pkg::SC_HIT:   state_d = frtrk_pkg::ST_CHUNK_UPD;
            frtrk_pkg::SC_BEST:  state_d = frtrk_pkg::ST_BEST_POST;
            frtrk_pkg::SC_PRUNE: state_d = frtrk_pkg::ST_DLV;
            frtrk_pkg::SC_EXP:   state_d = frtrk_pkg::ST_EXP_POST;
            default:             state_d = frtrk_pkg::ST_POLL_POST;
          endcase
        end
      end
      frtrk_pkg::ST_CHUNK_UPD: begin
        if (cand_v_q) state_d = hit_bad ? frtrk_pkg::ST_FIN : frtrk_pkg::ST_CHUNK_CNT;
        else          state_d = free_v ? frtrk_pkg::ST_CHUNK_CNT : frtrk_pkg::ST_FIN;
      end
      frtrk_pkg::ST_CHUNK_CNT: state_d = pend_over ? frtrk_pkg::ST_FIN : frtrk_pkg::ST_DLV;
      frtrk_pkg::ST_DLV:       state_d = frtrk_pkg::ST_SCAN;
      frtrk_pkg::ST_BEST_POST: state_d = cand_v_q ? frtrk_pkg::ST_SCAN : frtrk_pkg::ST_FIN;
      frtrk_pkg::ST_EXP_POST:  state_d = exp_ok ? frtrk_pkg::ST_DLV : frtrk_pkg::ST_FIN;
      frtrk_pkg::ST_POLL_POST: state_d = cand_v_q ? frtrk_pkg::ST_POLL_EVAL : frtrk_pkg::ST_FIN;
      frtrk_pkg::ST_POLL_EVAL: state_d = frtrk_pkg::ST_SCAN;
      frtrk_pkg::ST_FIN:       state_d = frtrk_pkg::ST_IDLE;
      default:                 state_d = frtrk_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d     = mode_q;
    valid_d    = valid_q;
    started_d  = started_q;
    need_key_d = need_key_q;
    expected_d = expected_q;
    newest_d   = newest_q;
    prev_d     = prev_q;
    prev_v_d   = prev_v_q;
    cand_v_d   = cand_v_q;
    cand_idx_d = cand_idx_q;
    cand_e_d   = cand_e_q;
    scan_a_d   = scan_a_q;
    rd_req     = 1'b0;
    rd_addr    = scan_a_q[SW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = cand_idx_q;
    mem_wdata  = cand_e_q;
    push       = 1'b0;
    push_res   = '0;
    fin        = 1'b0;

    unique case (state_q)
      frtrk_pkg::ST_IDLE: ;
      frtrk_pkg::ST_CHK: begin
        case (in_q.action)
          frtrk_pkg::ACT_CHUNK: begin
            if (bogus || stale) begin
              push             = 1'b1;
              push_res.kind    = frtrk_pkg::KIND_REJECTED;
              push_res.out_seq = in_q.frame_seq;
            end else begin
              if (!started_q || ((inw_dif != 32'd0) && !inw_dif[31]))
                newest_d = in_q.frame_seq;
              if (!started_q) expected_d = in_q.frame_seq;
              started_d = 1'b1;
              mode_d    = frtrk_pkg::SC_HIT;
              scan_a_d  = '0;
              cand_v_d  = 1'b0;
            end
          end
          frtrk_pkg::ACT_POLL: begin
            mode_d   = frtrk_pkg::SC_POLL;
            prev_v_d = 1'b0;
            scan_a_d = '0;
            cand_v_d = 1'b0;
          end
          frtrk_pkg::ACT_RESET: begin
            valid_d       = '0;
            need_key_d    = 1'b1;
            started_d     = 1'b0;
            push          = 1'b1;
            push_res.kind = frtrk_pkg::KIND_DONE;
          end
          default: begin
            push          = 1'b1;
            push_res.kind = frtrk_pkg::KIND_DONE;
          end
        endcase
      end
      frtrk_pkg::ST_SCAN: begin
        rd_req   = (scan_a_q < (SW + 1)'(SLOTS));
        if (rd_req) scan_a_d = scan_a_q + (SW + 1)'(1);
        if (match) begin
          if (mode_q == frtrk_pkg::SC_PRUNE) begin
            valid_d[rd_idx_q] = 1'b0;
          end else begin
            cand_v_d   = 1'b1;
            cand_idx_d = rd_idx_q;
            cand_e_d   = rd_data_q;
          end
        end
      end
      frtrk_pkg::ST_CHUNK_UPD: begin
        if (cand_v_q) begin
          if (hit_bad) begin
            push             = 1'b1;
            push_res.kind    = frtrk_pkg::KIND_REJECTED;
            push_res.out_seq = in_q.frame_seq;
          end else begin
            mem_we             = 1'b1;
            mem_wdata.received = cand_e_q.received | bit_mask;
            mem_wdata.have     = cand_e_q.have + 7'd1;
          end
        end else if (!free_v) begin
          valid_d          = '0;
          need_key_d       = 1'b1;
          push             = 1'b1;
          push_res.kind    = frtrk_pkg::KIND_FLUSHED;
          push_res.out_seq = in_q.frame_seq;
        end else begin
          mem_we                 = 1'b1;
          mem_waddr              = free_idx;
          mem_wdata.seq          = in_q.frame_seq;
          mem_wdata.total        = in_q.chunk_count[6:0];
          mem_wdata.have         = 7'd1;
          mem_wdata.key          = in_q.is_keyframe;
          mem_wdata.received     = bit_mask;
          mem_wdata.first_ms     = in_q.now_ms;
          mem_wdata.last_nack_ms = '0;
          mem_wdata.nacked       = 1'b0;
          valid_d[free_idx]      = 1'b1;
          cand_idx_d             = free_idx;
          cand_e_d.key           = in_q.is_keyframe;
        end
      end
      frtrk_pkg::ST_CHUNK_CNT: begin
        push             = 1'b1;
        push_res.out_seq = in_q.frame_seq;
        if (pend_over) begin
          valid_d       = '0;
          need_key_d    = 1'b1;
          push_res.kind = frtrk_pkg::KIND_FLUSHED;
        end else begin
          push_res.kind         = frtrk_pkg::KIND_STORED;
          push_res.slot         = 4'(cand_idx_q);
          push_res.out_keyframe = cand_e_q.key;
        end
      end
      frtrk_pkg::ST_DLV: begin
        mode_d   = need_key_q ? frtrk_pkg::SC_BEST : frtrk_pkg::SC_EXP;
        scan_a_d = '0;
        cand_v_d = 1'b0;
      end
      frtrk_pkg::ST_BEST_POST: begin
        if (cand_v_q) begin
          expected_d = cand_e_q.seq;
          need_key_d = 1'b0;
          mode_d     = frtrk_pkg::SC_PRUNE;
          scan_a_d   = '0;
        end
      end
      frtrk_pkg::ST_EXP_POST: begin
        if (exp_ok) begin
          push                  = 1'b1;
          push_res.kind         = frtrk_pkg::KIND_DELIVERED;
          push_res.out_seq      = cand_e_q.seq;
          push_res.slot         = 4'(cand_idx_q);
          push_res.out_keyframe = cand_e_q.key;
          valid_d[cand_idx_q]   = 1'b0;
          expected_d            = expected_q + 32'd1;
        end
      end
      frtrk_pkg::ST_POLL_POST: begin
        if (cand_v_q) begin
          prev_d   = cand_e_q.seq;
          prev_v_d = 1'b1;
        end else begin
          push          = 1'b1;
          push_res.kind = frtrk_pkg::KIND_DONE;
        end
      end
      frtrk_pkg::ST_POLL_EVAL: begin
        scan_a_d = '0;
        cand_v_d = 1'b0;
        if (cand_e_q.have != cand_e_q.total) begin
          if (drop) begin
            valid_d[cand_idx_q] = 1'b0;
            need_key_d          = 1'b1;
          end else if (nack_go) begin
            push                   = 1'b1;
            push_res.kind          = frtrk_pkg::KIND_NACK;
            push_res.out_seq       = cand_e_q.seq;
            push_res.slot          = 4'(cand_idx_q);
            push_res.out_keyframe  = cand_e_q.key;
            push_res.missing_mask  = ~cand_e_q.received & full_mask;
            mem_we                 = 1'b1;
            mem_wdata.nacked       = 1'b1;
            mem_wdata.last_nack_ms = in_q.now_ms;
          end
        end
      end
      frtrk_pkg::ST_FIN: fin = 1'b1;
      default: ;
    endcase

    // one result is held back until the next one or the end shows up
    res_valid_d = 1'b0;
    res_d       = pend_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    if (push) begin
      res_valid_d = pend_v_q;
      res_d.last  = 1'b0;
      pend_d      = push_res;
      pend_v_d    = 1'b1;
    end else if (fin) begin
      res_valid_d = pend_v_q;
      res_d.last  = 1'b1;
      pend_v_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= frtrk_pkg::ST_IDLE;
      mode_q        <= frtrk_pkg::SC_HIT;
      max_pending_q <= 4'd8;
      drop_after_q  <= 16'd500;
      nack_after_q  <= 16'd20;
      nack_repeat_q <= 16'd40;
      valid_q       <= '0;
      started_q     <= 1'b0;
      need_key_q    <= 1'b1;
      expected_q    <= '0;
      newest_q      <= '0;
      prev_q        <= '0;
      prev_v_q      <= 1'b0;
      cand_v_q      <= 1'b0;
      cand_idx_q    <= '0;
      scan_a_q      <= '0;
      rd_v_q        <= 1'b0;
      rd_idx_q      <= '0;
      res_valid_q   <= 1'b0;
      pend_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      valid_q     <= valid_d;
      started_q   <= started_d;
      need_key_q  <= need_key_d;
      expected_q  <= expected_d;
      newest_q    <= newest_d;
      prev_q      <= prev_d;
      prev_v_q    <= prev_v_d;
      cand_v_q    <= cand_v_d;
      cand_idx_q  <= cand_idx_d;
      scan_a_q    <= scan_a_d;
      rd_v_q      <= rd_req;
      rd_idx_q    <= rd_addr;
      res_valid_q <= res_valid_d;
      pend_v_q    <= pend_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          frtrk_pkg::CFG_MAX_PENDING:   max_pending_q <= cfg_wdata_i[3:0];
          frtrk_pkg::CFG_DROP_AFTER_MS: drop_after_q  <= cfg_wdata_i;
          frtrk_pkg::CFG_NACK_AFTER_MS: nack_after_q  <= cfg_wdata_i;
          default:                      nack_repeat_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == frtrk_pkg::ST_IDLE && start_i) in_q <= in_i;
    cand_e_q <= cand_e_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
  end

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[rd_addr];
  end

endmodule
